### hw/rtl/pse_pkg.sv
// Shared constants, character codes and ALU types for the postfix evaluator.
// Used by pse_alu and postfix_stack_evaluator; depends on nothing.
`timescale 1ns / 1ps

package pse_pkg;

    localparam int DATA_W      = 32;
    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int STEP_W      = $clog2(DATA_W);

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_LPAR  = 8'd40;
    localparam logic [7:0] CH_RPAR  = 8'd41;
    localparam logic [7:0] CH_MUL   = 8'd42;
    localparam logic [7:0] CH_ADD   = 8'd43;
    localparam logic [7:0] CH_SUB   = 8'd45;
    localparam logic [7:0] CH_DIV   = 8'd47;

    localparam logic [DATA_W-1:0] NEG_ONE = '1;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

endpackage

### hw/rtl/pse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the value stack.
`timescale 1ns / 1ps

module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/pse_alu.sv
// Iterative arithmetic unit: add/sub in one step, shift-add multiply and
// restoring divide one bit per step, all through a single shared adder.
// Depends on pse_pkg.
`timescale 1ns / 1ps

module pse_alu (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pse_pkg::t_alu_req         i_req,
    input  logic [pse_pkg::DATA_W-1:0] i_lhs,
    input  logic [pse_pkg::DATA_W-1:0] i_rhs,
    output logic                      o_done,
    output logic [pse_pkg::DATA_W-1:0] o_result
);

    localparam int W = pse_pkg::DATA_W;

    logic                     r_busy;
    logic                     r_fix;
    pse_pkg::t_alu_op         r_op;
    logic [pse_pkg::STEP_W-1:0] r_cnt;
    logic [W-1:0]             r_acc;
    logic [W-1:0]             r_a;
    logic [W-1:0]             r_b;
    logic                     r_neg;
    logic                     r_done;
    logic                     n_done;
    logic [W-1:0]             r_result;

    logic [W:0]   add_x;
    logic [W:0]   add_y;
    logic         add_cin;
    logic [W+1:0] add_sum;
    logic         carry;
    logic         last_step;
    logic [W-1:0] lhs_mag;
    logic [W-1:0] rhs_mag;

    assign lhs_mag = i_lhs[W-1] ? (W'(0) - i_lhs) : i_lhs;
    assign rhs_mag = i_rhs[W-1] ? (W'(0) - i_rhs) : i_rhs;

    // One shared adder; divide uses it as a compare-and-subtract.
    always_comb begin
        add_x   = {1'b0, r_a};
        add_y   = {1'b0, r_b};
        add_cin = 1'b0;
        if (r_fix) begin
            add_x   = '0;
            add_y   = r_neg ? ~{1'b0, r_a} : {1'b0, r_a};
            add_cin = r_neg;
        end else begin
            case (r_op)
                pse_pkg::ALU_ADD: begin
                    add_cin = 1'b0;
                end
                pse_pkg::ALU_SUB: begin
                    add_y   = ~{1'b0, r_b};
                    add_cin = 1'b1;
                end
                pse_pkg::ALU_MUL: begin
                    add_x = {1'b0, r_acc};
                    add_y = r_b[0] ? {1'b0, r_a} : '0;
                end
                pse_pkg::ALU_DIV: begin
                    add_x   = {r_acc, r_a[W-1]};
                    add_y   = ~{1'b0, r_b};
                    add_cin = 1'b1;
                end
                default: begin
                    add_cin = 1'b0;
                end
            endcase
        end
        add_sum = {1'b0, add_x} + {1'b0, add_y} + {{(W+1){1'b0}}, add_cin};
    end

    assign carry     = add_sum[W+1];
    assign last_step = (r_cnt == pse_pkg::STEP_W'(W - 1));

    // result is final after the sign fix, a single add/sub step or the last multiply step
    assign n_done = r_busy && !i_req.start &&
                    (r_fix || r_op == pse_pkg::ALU_ADD || r_op == pse_pkg::ALU_SUB ||
                     (r_op == pse_pkg::ALU_MUL && last_step));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= n_done;
            if (i_req.start) begin
                r_op   <= i_req.op;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_fix  <= 1'b0;
                r_busy <= 1'b1;
                if (i_req.op == pse_pkg::ALU_DIV) begin
                    r_a   <= lhs_mag;
                    r_b   <= rhs_mag;
                    r_neg <= i_lhs[W-1] ^ i_rhs[W-1];
                end else begin
                    r_a   <= i_lhs;
                    r_b   <= i_rhs;
                    r_neg <= 1'b0;
                end
            end else if (r_busy) begin
                if (r_fix) begin
                    r_result <= add_sum[W-1:0];
                    r_busy   <= 1'b0;
                    r_fix    <= 1'b0;
                end else begin
                    case (r_op)
                        pse_pkg::ALU_ADD, pse_pkg::ALU_SUB: begin
                            r_result <= add_sum[W-1:0];
                            r_busy   <= 1'b0;
                        end
                        pse_pkg::ALU_MUL: begin
                            r_acc <= add_sum[W-1:0];
                            r_a   <= {r_a[W-2:0], 1'b0};
                            r_b   <= {1'b0, r_b[W-1:1]};
                            r_cnt <= r_cnt + pse_pkg::STEP_W'(1);
                            if (last_step) begin
                                r_result <= add_sum[W-1:0];
                                r_busy   <= 1'b0;
                            end
                        end
                        pse_pkg::ALU_DIV: begin
                            // remainder stays below the divisor, so 32 bits hold it
                            r_acc <= carry ? add_sum[W-1:0] : add_x[W-1:0];
                            r_a   <= {r_a[W-2:0], carry};
                            r_cnt <= r_cnt + pse_pkg::STEP_W'(1);
                            if (last_step) begin
                                r_fix <= 1'b1;
                            end
                        end
                        default: begin
                            r_busy <= 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

### hw/rtl/postfix_stack_evaluator.sv
// Top level of the postfix evaluator: sequencer, value stack and output register.
// Depends on pse_pkg, pse_ram and pse_alu.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one postfix character in i_symbol
//   and i_last, which marks the final character of an expression. A transaction
//   completes when i_valid is high and o_stall is low; o_stall is high while a
//   character is being worked on.
//   Output channel (o_valid / i_stall) carries one result per expression, on the
//   last character: the final popped value (-1 for an empty stack) and the two
//   sticky flags for overflow and division by zero.
//   A digit is pushed directly; an operator pops its two operands, then a paren
//   drops them, a divide by zero pushes -1, and add, subtract, multiply and divide
//   (32 divider steps, sign fix and result handoff) run in the ALU and push the
//   result. A last character adds the final pop into the output register. The
//   shared ALU paces multiply and divide; a pop waits on the registered RAM read.
//   Reset empties the stack and clears both sticky flags and the output valid.
//   If the receiver stalls while a result is held, the next expression can still
//   run; its own final pop waits until the output register is free.
`timescale 1ns / 1ps

module postfix_stack_evaluator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_symbol,
    input  logic               i_last,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_result_value,
    output logic               o_stack_overflowed,
    output logic               o_divided_by_zero
);

    localparam int W = pse_pkg::DATA_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RHS_A,
        S_RHS_B,
        S_LHS_A,
        S_LHS_B,
        S_EXEC,
        S_ALU_WAIT,
        S_PUSH,
        S_END_A,
        S_END_B
    } t_state;

    t_state                      r_state, n_state;
    logic [7:0]                  r_sym, n_sym;
    logic                        r_last, n_last;
    logic [pse_pkg::CNT_W-1:0]   r_count, n_count;
    logic [W-1:0]                r_rhs, n_rhs;
    logic [W-1:0]                r_lhs, n_lhs;
    logic [W-1:0]                r_res, n_res;
    logic                        r_ovf, n_ovf;
    logic                        r_dz, n_dz;
    logic                        r_o_valid, n_o_valid;
    logic [W-1:0]                r_o_value, n_o_value;
    logic                        r_o_ovf, n_o_ovf;
    logic                        r_o_dz, n_o_dz;

    logic                        in_fire;
    logic                        out_free;
    logic                        is_op;
    logic                        stack_empty;
    logic                        stack_full;
    logic [W-1:0]                pop_value;
    logic [pse_pkg::CNT_W-1:0]   top_idx;
    logic [W-1:0]                rd_data;
    logic                        wr_en;
    pse_pkg::t_alu_req           alu_req;
    logic                        alu_done;
    logic [W-1:0]                alu_result;
    pse_pkg::t_alu_op            sym_op;

    assign in_fire     = i_valid && (r_state == S_IDLE);
    assign out_free    = !r_o_valid || !i_stall;
    assign stack_empty = (r_count == '0);
    assign stack_full  = (r_count == pse_pkg::CNT_W'(pse_pkg::STACK_DEPTH));
    assign top_idx     = r_count - pse_pkg::CNT_W'(1);
    assign pop_value   = stack_empty ? pse_pkg::NEG_ONE : rd_data;
    assign wr_en       = (r_state == S_PUSH) && !stack_full;

    assign is_op = (i_symbol == pse_pkg::CH_LPAR) || (i_symbol == pse_pkg::CH_RPAR) ||
                   (i_symbol == pse_pkg::CH_ADD)  || (i_symbol == pse_pkg::CH_SUB)  ||
                   (i_symbol == pse_pkg::CH_MUL)  || (i_symbol == pse_pkg::CH_DIV);

    always_comb begin
        case (r_sym)
            pse_pkg::CH_SUB: sym_op = pse_pkg::ALU_SUB;
            pse_pkg::CH_MUL: sym_op = pse_pkg::ALU_MUL;
            pse_pkg::CH_DIV: sym_op = pse_pkg::ALU_DIV;
            default:         sym_op = pse_pkg::ALU_ADD;
        endcase
    end

    // Stack RAM reads at the current top every cycle; a pop holds the count in state
    // A and captures the data in the state after it (B).
    pse_ram #(
        .WIDTH (W),
        .DEPTH (pse_pkg::STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[pse_pkg::ADDR_W-1:0]),
        .i_wdata (r_res),
        .i_raddr (top_idx[pse_pkg::ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    pse_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_lhs    (r_lhs),
        .i_rhs    (r_rhs),
        .o_done   (alu_done),
        .o_result (alu_result)
    );

    always_comb begin
        n_state   = r_state;
        n_sym     = r_sym;
        n_last    = r_last;
        n_count   = r_count;
        n_rhs     = r_rhs;
        n_lhs     = r_lhs;
        n_res     = r_res;
        n_ovf     = r_ovf;
        n_dz      = r_dz;
        n_o_valid = r_o_valid && i_stall;
        n_o_value = r_o_value;
        n_o_ovf   = r_o_ovf;
        n_o_dz    = r_o_dz;
        alu_req.start = 1'b0;
        alu_req.op    = sym_op;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_sym  = i_symbol;
                    n_last = i_last;
                    n_res  = W'(i_symbol) - W'(pse_pkg::CH_ZERO);
                    n_state = is_op ? S_RHS_A : S_PUSH;
                end
            end
            S_RHS_A: n_state = S_RHS_B;
            S_RHS_B: begin
                n_rhs = pop_value;
                if (!stack_empty) begin
                    n_count = r_count - pse_pkg::CNT_W'(1);
                end
                n_state = S_LHS_A;
            end
            S_LHS_A: n_state = S_LHS_B;
            S_LHS_B: begin
                n_lhs = pop_value;
                if (!stack_empty) begin
                    n_count = r_count - pse_pkg::CNT_W'(1);
                end
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (r_sym == pse_pkg::CH_LPAR || r_sym == pse_pkg::CH_RPAR) begin
                    n_state = r_last ? S_END_A : S_IDLE;
                end else if (r_sym == pse_pkg::CH_DIV && r_rhs == '0) begin
                    n_dz    = 1'b1;
                    n_res   = pse_pkg::NEG_ONE;
                    n_state = S_PUSH;
                end else begin
                    alu_req.start = 1'b1;
                    n_state       = S_ALU_WAIT;
                end
            end
            S_ALU_WAIT: begin
                if (alu_done) begin
                    n_res   = alu_result;
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (stack_full) begin
                    n_ovf = 1'b1;
                end else begin
                    n_count = r_count + pse_pkg::CNT_W'(1);
                end
                n_state = r_last ? S_END_A : S_IDLE;
            end
            S_END_A: n_state = S_END_B;
            S_END_B: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_value = pop_value;
                    n_o_ovf   = r_ovf;
                    n_o_dz    = r_dz;
                    n_count   = '0;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_dz      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_dz      <= n_dz;
            r_o_valid <= n_o_valid;
        end
        r_sym     <= n_sym;
        r_last    <= n_last;
        r_rhs     <= n_rhs;
        r_lhs     <= n_lhs;
        r_res     <= n_res;
        r_o_value <= n_o_value;
        r_o_ovf   <= n_o_ovf;
        r_o_dz    <= n_o_dz;
    end

    assign o_stall            = (r_state != S_IDLE);
    assign o_valid            = r_o_valid;
    assign o_result_value     = signed'(r_o_value);
    assign o_stack_overflowed = r_o_ovf;
    assign o_divided_by_zero  = r_o_dz;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pse_pkg::CNT_W'(pse_pkg::STACK_DEPTH))
        else $error("stack count beyond depth");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_END_B && out_free) |=> (r_count == '0 && r_o_valid))
        else $error("final pop did not empty stack or post result");

    a_dz_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dz |=> r_dz)
        else $error("divide-by-zero flag dropped");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |=> r_ovf)
        else $error("overflow flag dropped");

    a_alu_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_done |-> (r_state == S_ALU_WAIT))
        else $error("ALU finished outside wait state");

endmodule

### tb/postfix_stack_evaluator_test.sv
// Self-checking testbench for postfix_stack_evaluator: directed and random postfix
// expressions, an in-bench stack predictor, and random idling on both channels.
// Depends on pse_pkg and the postfix_stack_evaluator RTL.
`timescale 1ns / 1ps

module postfix_stack_evaluator_test;

    localparam int CHAR_TARGET = 1250;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        logic [7:0] symbol;
        logic       last;
    } t_char_item;

    typedef struct {
        logic [pse_pkg::DATA_W-1:0] value;
        logic                       overflowed;
        logic                       div_zero;
    } t_eval_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               sym_valid = 1'b0;
    logic               sym_stall;
    logic [7:0]         sym_char = 8'd0;
    logic               sym_last = 1'b0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    logic signed [31:0] res_value;
    logic               res_overflowed;
    logic               res_div_zero;

    postfix_stack_evaluator u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (sym_valid),
        .o_stall            (sym_stall),
        .i_symbol           (sym_char),
        .i_last             (sym_last),
        .o_valid            (res_valid),
        .i_stall            (res_stall),
        .o_result_value     (res_value),
        .o_stack_overflowed (res_overflowed),
        .o_divided_by_zero  (res_div_zero)
    );

    t_char_item   pending_chars[$];
    t_eval_result expected_results[$];

    // predictor state
    logic [pse_pkg::DATA_W-1:0] eval_stack [pse_pkg::STACK_DEPTH];
    int                eval_depth = 0;
    logic              overflow_seen = 1'b0;
    logic              divzero_seen = 1'b0;

    int  chars_total = 0;
    int  chars_taken = 0;
    int  results_checked = 0;
    int  exprs_total = 0;
    int  error_count = 0;
    int  cycle_count = 0;
    logic took_char = 1'b0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic bit is_operator(input logic [7:0] sym);
        return sym == pse_pkg::CH_LPAR || sym == pse_pkg::CH_RPAR ||
               sym == pse_pkg::CH_ADD || sym == pse_pkg::CH_SUB ||
               sym == pse_pkg::CH_MUL || sym == pse_pkg::CH_DIV;
    endfunction

    function automatic void push_value(input logic [pse_pkg::DATA_W-1:0] v);
        if (eval_depth < pse_pkg::STACK_DEPTH) begin
            eval_stack[eval_depth] = v;
            eval_depth++;
        end else begin
            overflow_seen = 1'b1;
        end
    endfunction

    function automatic logic [pse_pkg::DATA_W-1:0] pop_value();
        if (eval_depth == 0)
            return pse_pkg::NEG_ONE;
        eval_depth--;
        return eval_stack[eval_depth];
    endfunction

    task automatic evaluate_symbol(input logic [7:0] sym, input logic is_last);
        logic [pse_pkg::DATA_W-1:0] rhs, lhs, mag_l, mag_r, quot;
        t_eval_result      res;
        if (is_operator(sym)) begin
            rhs = pop_value();
            lhs = pop_value();
            case (sym)
                pse_pkg::CH_ADD: push_value(lhs + rhs);
                pse_pkg::CH_SUB: push_value(lhs - rhs);
                pse_pkg::CH_MUL: push_value(lhs * rhs);
                pse_pkg::CH_DIV: begin
                    if (rhs == '0) begin
                        divzero_seen = 1'b1;
                        push_value(pse_pkg::NEG_ONE);
                    end else begin
                        // magnitude divide, then fix sign: truncates toward zero
                        mag_l = lhs[pse_pkg::DATA_W-1] ? -lhs : lhs;
                        mag_r = rhs[pse_pkg::DATA_W-1] ? -rhs : rhs;
                        quot  = mag_l / mag_r;
                        push_value((lhs[pse_pkg::DATA_W-1] ^ rhs[pse_pkg::DATA_W-1]) ?
                                   -quot : quot);
                    end
                end
                default: ;  // parens drop both operands
            endcase
        end else begin
            push_value({24'd0, sym} - {24'd0, pse_pkg::CH_ZERO});
        end
        if (is_last) begin
            res.value      = pop_value();
            res.overflowed = overflow_seen;
            res.div_zero   = divzero_seen;
            eval_depth     = 0;
            expected_results.push_back(res);
        end
    endtask

    // monitor: result check first, then prediction for a character taken this edge
    always @(posedge i_clk) begin
        t_eval_result want;
        if (i_rst_n && res_valid === 1'b1 && !res_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d", res_value));
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (res_value !== want.value)
                    report_mismatch($sformatf("result %0d: value %0d, expected %0d",
                                    results_checked, res_value, $signed(want.value)));
                if (res_overflowed !== want.overflowed)
                    report_mismatch($sformatf("result %0d: overflow flag %b, expected %b",
                                    results_checked, res_overflowed, want.overflowed));
                if (res_div_zero !== want.div_zero)
                    report_mismatch($sformatf("result %0d: div-zero flag %b, expected %b",
                                    results_checked, res_div_zero, want.div_zero));
            end
        end
        if (i_rst_n && (sym_valid && !sym_stall) === 1'b1) begin
            evaluate_symbol(sym_char, sym_last);
            chars_taken <= chars_taken + 1;
            took_char   <= 1'b1;
        end else begin
            took_char   <= 1'b0;
        end
    end

    // driver: sender and receiver idle rates change with progress through the stimulus
    always @(negedge i_clk) begin
        int send_idle, recv_idle;
        if (chars_taken < chars_total / 3) begin
            send_idle = 16;
            recv_idle = 75;
        end else if (chars_taken < 2 * chars_total / 3) begin
            send_idle = 75;
            recv_idle = 16;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
        if (!i_rst_n) begin
            sym_valid <= 1'b0;
        end else if (!sym_valid || took_char) begin
            if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle) begin
                sym_valid <= 1'b1;
                sym_char  <= pending_chars[0].symbol;
                sym_last  <= pending_chars[0].last;
                pending_chars.pop_front();
            end else begin
                sym_valid <= 1'b0;
            end
        end
        res_stall <= ($urandom_range(99) < recv_idle);
    end

    task automatic add_symbol(input logic [7:0] sym, input logic is_last);
        t_char_item item;
        item.symbol = sym;
        item.last   = is_last;
        pending_chars.push_back(item);
        chars_total++;
        if (is_last)
            exprs_total++;
    endtask

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++)
            add_symbol(s[k], k == s.len() - 1);
    endtask

    function automatic logic [7:0] random_operand();
        logic [7:0] sym;
        if ($urandom_range(99) < 85)
            return pse_pkg::CH_ZERO + 8'($urandom_range(9));
        do
            sym = 8'($urandom_range(255));
        while (is_operator(sym));
        return sym;
    endfunction

    function automatic logic [7:0] random_operator(input bit with_parens);
        case ($urandom_range(with_parens ? 5 : 3))
            0: return pse_pkg::CH_ADD;
            1: return pse_pkg::CH_SUB;
            2: return pse_pkg::CH_MUL;
            3: return pse_pkg::CH_DIV;
            4: return pse_pkg::CH_LPAR;
            default: return pse_pkg::CH_RPAR;
        endcase
    endfunction

    task automatic add_random_expr();
        logic [7:0] syms[$];
        int kind, operands, placed, depth, len;
        kind = $urandom_range(99);
        if (kind < 80) begin
            // well-formed expression with random content
            operands = $urandom_range(1, 8);
            placed   = 0;
            depth    = 0;
            while (placed < operands || depth > 1) begin
                if (placed < operands && (depth < 2 || $urandom_range(1) == 0)) begin
                    syms.push_back(random_operand());
                    placed++;
                    depth++;
                end else begin
                    syms.push_back(random_operator(1'b0));
                    depth--;
                end
            end
        end else if (kind < 92) begin
            len = $urandom_range(1, 20);
            repeat (len)
                syms.push_back($urandom_range(1) ? 8'($urandom_range(255))
                                                 : random_operator(1'b1));
        end else begin
            // runs up to or past the stack depth
            len = $urandom_range(pse_pkg::STACK_DEPTH - 1, pse_pkg::STACK_DEPTH + 3);
            repeat (len)
                syms.push_back(random_operand());
            repeat ($urandom_range(0, 3))
                syms.push_back(random_operator(1'b1));
        end
        foreach (syms[k])
            add_symbol(syms[k], k == syms.size() - 1);
    endtask

    initial begin
        // directed: flags stay clear until the divide-by-zero and overflow cases at the end
        add_text("7");
        add_text("+");
        add_symbol(8'hFF, 1'b0);
        add_symbol(8'h00, 1'b0);
        add_symbol(pse_pkg::CH_SUB, 1'b1);
        add_text("97./*");
        add_text("12)");
        add_text("1(");
        // 2^31 wraps to the most negative value, then divided by -1
        repeat (2) add_symbol(8'd176, 1'b0);
        add_symbol(pse_pkg::CH_MUL, 1'b0);
        repeat (2) begin
            add_symbol(8'd176, 1'b0);
            add_symbol(pse_pkg::CH_MUL, 1'b0);
        end
        add_text("8*01-/");
        add_text("50/");
        add_text("12345678901234567");

        while (chars_total < CHAR_TARGET)
            add_random_expr();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_chars.size() != 0 || sym_valid)
            @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Fed %0d characters in %0d expressions; %0d results checked, %0d errors.",
                 chars_taken, exprs_total, results_checked, error_count);
        $display("Idling ran sender-light, receiver-light, then back-to-back.");
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/pse_pkg.sv
hw/rtl/pse_ram.sv
hw/rtl/pse_alu.sv
hw/rtl/postfix_stack_evaluator.sv
tb/postfix_stack_evaluator_test.sv
